// ===== src/ecae_pkg.sv =====
`default_nettype none
package ecae_pkg;

  localparam int unsigned DefTableSize = 64;
  localparam int unsigned KeyW         = 64;
  localparam int unsigned TagW         = 32;
  localparam int unsigned ChanW        = 8;
  localparam int unsigned TefW         = 32;
  localparam int unsigned IdxW         = 7;
  localparam int unsigned LinkIdxW     = 6;
  localparam int unsigned LinkW        = LinkIdxW + 1;

  // request codes
  typedef enum logic [1:0] {
    REQ_SEARCH_WR = 2'd0,
    REQ_WALK_WR   = 2'd1,
    REQ_FLIP      = 2'd2,
    REQ_EVENT     = 2'd3
  } req_e;

  // controller to datapath
  typedef struct packed {
    logic wr_search;
    logic wr_walk;
    logic flip;
    logic start;
    logic scan_rd;
    logic head_chk;
    logic walk_rd;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic head_ok;
    logic last;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/ecae_if.sv =====
`default_nettype none
interface ecae_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [6:0]  table_index;
  logic [63:0] event_id;
  logic        link_valid;
  logic [5:0]  link_index;
  logic signed [63:0] delay;
  logic [31:0] action_tag;
  logic [7:0]  channel_number;
  logic [63:0] param;
  logic [31:0] tef;
  logic [63:0] event_time;

  modport source (output valid, req_type, table_index, event_id, link_valid, link_index,
                  delay, action_tag, channel_number, param, tef, event_time,
                  input ready);
  modport sink (input valid, req_type, table_index, event_id, link_valid, link_index,
                delay, action_tag, channel_number, param, tef, event_time,
                output ready);
endinterface

interface ecae_act_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_channel;
  logic [31:0] out_tag;
  logic [63:0] out_event;
  logic [63:0] out_param;
  logic [31:0] out_tef;
  logic [63:0] deadline;
  logic        last_action;

  modport source (output valid, out_channel, out_tag, out_event, out_param, out_tef,
                  deadline, last_action, input ready);
  modport sink (input valid, out_channel, out_tag, out_event, out_param, out_tef,
                deadline, last_action, output ready);
endinterface
`default_nettype wire

// ===== src/ecae_ram.sv =====
`default_nettype none
module ecae_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== src/ecae_ctrl.sv =====
`default_nettype none
module ecae_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  input  wire logic [1:0]        req_type_i,
  output logic                   req_ready_o,
  input  wire logic              act_ready_i,
  output logic                   act_valid_o,
  input  wire ecae_pkg::sts_t    sts_i,
  output ecae_pkg::cmd_t         cmd_o
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_SCAN_END, ST_HEAD, ST_WALK_RD, ST_WALK_DATA, ST_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign act_valid_o = out_valid_q;
  assign accept      = req_valid_i & req_ready_o;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            ecae_pkg::REQ_SEARCH_WR: cmd_o.wr_search = 1'b1;
            ecae_pkg::REQ_WALK_WR:   cmd_o.wr_walk   = 1'b1;
            ecae_pkg::REQ_FLIP:      cmd_o.flip      = 1'b1;
            default:                 cmd_o.start     = 1'b1;
          endcase
        end
      end
      ST_SCAN:      cmd_o.scan_rd  = 1'b1;
      ST_HEAD:      cmd_o.head_chk = 1'b1;
      ST_WALK_RD:   cmd_o.walk_rd  = 1'b1;
      ST_WALK_DATA: cmd_o.load_out = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && req_type_i == ecae_pkg::REQ_EVENT) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (sts_i.scan_last) state_q <= ST_SCAN_END;
        end
        ST_SCAN_END: state_q <= ST_HEAD;
        ST_HEAD:     state_q <= sts_i.head_ok ? ST_WALK_RD : ST_IDLE;
        ST_WALK_RD:  state_q <= ST_WALK_DATA;
        ST_WALK_DATA: begin
          state_q     <= ST_OUT;
          out_valid_q <= 1'b1;
        end
        ST_OUT: begin
          if (act_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= sts_i.last ? ST_IDLE : ST_WALK_RD;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/ecae_dp.sv =====
`default_nettype none
module ecae_dp #(
  parameter int unsigned TableSize = ecae_pkg::DefTableSize
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ecae_pkg::cmd_t cmd_i,
  output ecae_pkg::sts_t      sts_o,
  ecae_req_if.sink            req,
  ecae_act_if.source          act
);
  localparam int unsigned SearchN = 2 * TableSize;
  localparam int unsigned SAW     = $clog2(2 * SearchN);
  localparam int unsigned WAW     = $clog2(2 * TableSize);
  localparam int unsigned CW      = $clog2(SearchN);
  localparam int unsigned NW      = $clog2(TableSize + 1);
  localparam int unsigned SW      = ecae_pkg::KeyW + ecae_pkg::LinkW;
  localparam int unsigned WW      = ecae_pkg::LinkW + 64 + ecae_pkg::TagW + ecae_pkg::ChanW;

  logic           bank_q;
  logic [63:0]    ev_q, param_q, time_q;
  logic [31:0]    tef_q;
  logic [CW-1:0]  cnt_q;
  logic           cmp_pend_q;
  logic           found_q;
  logic [63:0]    best_key_q;
  logic [ecae_pkg::LinkW-1:0]    best_head_q;
  logic [ecae_pkg::LinkIdxW-1:0] pos_q;
  logic [NW-1:0]  n_q;
  logic           last_q;

  logic [SAW-1:0] s_waddr, s_raddr;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [SW-1:0]  s_wdata, s_rdata;
  logic [WW-1:0]  w_wdata, w_rdata;
  logic           s_we, w_we;
  logic [63:0]    key;
  logic [ecae_pkg::LinkW-1:0] w_link;
  logic [63:0]    w_delay;
  logic [31:0]    w_tag;
  logic [7:0]     w_chan;
  logic           more;

  // writes go to the inactive bank
  assign s_we    = cmd_i.wr_search && ({1'b0, req.table_index} < 8'(SearchN));
  assign w_we    = cmd_i.wr_walk && ({1'b0, req.table_index} < 8'(TableSize));
  assign s_waddr = bank_q ? SAW'(req.table_index) : SAW'(SearchN) + SAW'(req.table_index);
  assign w_waddr = bank_q ? WAW'(req.table_index) : WAW'(TableSize) + WAW'(req.table_index);
  assign s_wdata = {req.link_valid, req.link_index, req.event_id};
  assign w_wdata = {req.link_valid, req.link_index, req.delay, req.action_tag,
                    req.channel_number};
  assign s_raddr = bank_q ? SAW'(SearchN) + SAW'(cnt_q) : SAW'(cnt_q);
  assign w_raddr = bank_q ? WAW'(TableSize) + WAW'(pos_q) : WAW'(pos_q);

  ecae_ram #(.Width(SW), .Depth(2 * SearchN)) u_search_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(cmd_i.scan_rd), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  ecae_ram #(.Width(WW), .Depth(2 * TableSize)) u_walk_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .re_i(cmd_i.walk_rd), .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  assign key = s_rdata[63:0];
  assign {w_link, w_delay, w_tag, w_chan} = w_rdata;
  assign more = w_link[ecae_pkg::LinkIdxW] &&
                ({1'b0, w_link[ecae_pkg::LinkIdxW-1:0]} < 7'(TableSize));

  assign sts_o.scan_last = (cnt_q == CW'(SearchN - 1));
  assign sts_o.head_ok   = found_q && best_head_q[ecae_pkg::LinkIdxW] &&
                           ({1'b0, best_head_q[ecae_pkg::LinkIdxW-1:0]} < 7'(TableSize));
  assign sts_o.last      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q     <= 1'b0;
      cmp_pend_q <= 1'b0;
      found_q    <= 1'b0;
      cnt_q      <= '0;
    end else begin
      if (cmd_i.flip) bank_q <= ~bank_q;
      cmp_pend_q <= cmd_i.scan_rd;
      if (cmd_i.start) begin
        found_q <= 1'b0;
        cnt_q   <= '0;
      end else if (cmd_i.scan_rd && !sts_o.scan_last) begin
        cnt_q <= cnt_q + CW'(1);
      end
      // later index wins on equal keys
      if (cmp_pend_q && key <= ev_q && (!found_q || key >= best_key_q)) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ev_q    <= req.event_id;
      param_q <= req.param;
      tef_q   <= req.tef;
      time_q  <= req.event_time;
    end
    if (cmp_pend_q && key <= ev_q && (!found_q || key >= best_key_q)) begin
      best_key_q  <= key;
      best_head_q <= s_rdata[SW-1:64];
    end
    if (cmd_i.head_chk) begin
      pos_q <= best_head_q[ecae_pkg::LinkIdxW-1:0];
      n_q   <= '0;
    end
    if (cmd_i.load_out) begin
      act.out_channel <= w_chan;
      act.out_tag     <= w_tag;
      act.out_event   <= ev_q;
      act.out_param   <= param_q;
      act.out_tef     <= tef_q;
      act.deadline    <= time_q + w_delay;
      last_q          <= !more || (n_q == NW'(TableSize - 1));
      pos_q           <= w_link[ecae_pkg::LinkIdxW-1:0];
      n_q             <= n_q + NW'(1);
    end
  end

  assign act.last_action = last_q;
endmodule
`default_nettype wire

// ===== src/event_condition_action_engine_core.sv =====
`default_nettype none
// event condition action table engine
// req channel: one beat per request; search or walk writes land in the
//   inactive bank, a flip swaps banks, an event looks up the active bank
// act channel: one beat per action of the matched chain, last_action marks
//   the final beat of an event
// event flow: an event scans all twice-table-size search entries, one
//   search-memory read per cycle, then checks the best head and reads the
//   first walk entry before its first action beat is loaded into the output
//   register; each further action takes a walk-memory read, deadline add and
//   output beat, and waits while the receiver holds ready low
// requests are taken only while no event is in progress
// a stalled receiver simply holds the action beat in the output register
// reset: active bank 0, no event in progress; table contents are undefined
//   until written and need no clearing pass
module event_condition_action_engine_core #(
  parameter int unsigned TableSize = ecae_pkg::DefTableSize
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ecae_req_if.sink   req,
  ecae_act_if.source act
);
  ecae_pkg::cmd_t cmd;
  ecae_pkg::sts_t sts;

  // sequencing of scan and chain walk
  ecae_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i (req.valid),
    .req_type_i  (req.req_type),
    .req_ready_o (req.ready),
    .act_ready_i (act.ready),
    .act_valid_o (act.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // tables, best-key tracking and action payload
  ecae_dp #(.TableSize(TableSize)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .req   (req),
    .act   (act)
  );
endmodule
`default_nettype wire
